FILE: sv/pbdrc_pkg.sv
package pbdrc_pkg;

	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_FORWARD = 2'd1;
	localparam logic [1:0] OP_COUNT   = 2'd2;

	localparam logic [6:0] LIMIT_RESET = 7'd64;
	localparam logic [6:0] CNT_MAX     = 7'd127;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] source;
		logic [15:0] destination;
		logic [31:0] timestamp;
		logic [31:0] start_time;
		logic [31:0] end_time;
	} req_item_t;

	typedef struct packed {
		logic        accepted;
		logic        packet_valid;
		logic [15:0] out_source;
		logic [15:0] out_destination;
		logic [31:0] out_timestamp;
		logic [6:0]  match_count;
	} rsp_item_t;

	typedef struct packed {
		logic [15:0] source;
		logic [15:0] destination;
		logic [31:0] timestamp;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture request transaction
		logic start;  // arm scan, clear match state
		logic issue;  // read one entry
		logic commit; // update pointers, load result register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic       occ_zero;
		logic       scan_last;
		logic       out_free;
	} ctrl_status_t;

endpackage

FILE: sv/pbdrc_stream_if.sv
interface pbdrc_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/pbdrc_ctrl.sv
module pbdrc_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  pbdrc_pkg::ctrl_status_t status,
	output pbdrc_pkg::ctrl_cmd_t    cmd
);
	import pbdrc_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_START  = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       needs_scan;

	assign req_ready = (state_q == S_IDLE);
	assign needs_scan = !status.occ_zero &&
		(status.op == OP_ADD || status.op == OP_FORWARD || status.op == OP_COUNT);

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.load   = req_valid && req_ready;
		cmd.start  = (state_q == S_START);
		cmd.issue  = (state_q == S_SCAN);
		cmd.commit = (state_q == S_COMMIT) && status.out_free;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_START;
			end
			S_START: begin
				state_d = needs_scan ? S_SCAN : S_COMMIT;
			end
			S_SCAN: begin
				if (status.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (status.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/pbdrc_datapath.sv
module pbdrc_datapath #(
	parameter int DEPTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr,
	input  logic [6:0]              cfg_data,
	input  pbdrc_pkg::req_item_t    req_data,
	input  pbdrc_pkg::ctrl_cmd_t    cmd,
	output pbdrc_pkg::ctrl_status_t status,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output pbdrc_pkg::rsp_item_t    rsp_data
);
	import pbdrc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (32'(p) == DEPTH - 1) ? '0 : p + AW'(1);
	endfunction

	entry_t     mem [DEPTH];

	logic [6:0]    limit_q;
	req_item_t     req_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [OW-1:0] occ_q;
	logic [AW-1:0] scan_ptr_q;
	logic [OW-1:0] remain_q;
	logic          rd_valid_s1;
	entry_t        rd_data_s1;
	logic          dup_q;
	logic [6:0]    cnt_q;
	logic          out_valid_q;
	rsp_item_t     out_q;

	logic [OW-1:0] eff_limit;
	logic          hit_dup;
	logic          hit_cnt;
	logic          do_write;
	logic          do_pop;
	entry_t        new_entry;
	rsp_item_t     out_d;

	always_comb begin
		if (32'(limit_q) > 32'(DEPTH)) eff_limit = OW'(DEPTH);
		else if (limit_q == '0)        eff_limit = OW'(1);
		else                           eff_limit = OW'(limit_q);
	end

	assign hit_dup = rd_data_s1.source == req_q.source &&
		rd_data_s1.destination == req_q.destination &&
		rd_data_s1.timestamp == req_q.timestamp;
	assign hit_cnt = rd_data_s1.destination == req_q.destination &&
		rd_data_s1.timestamp >= req_q.start_time &&
		rd_data_s1.timestamp <= req_q.end_time;

	assign do_write = cmd.commit && req_q.operation == OP_ADD && !dup_q;
	assign do_pop   = cmd.commit && req_q.operation == OP_FORWARD && occ_q != '0;

	assign new_entry.source      = req_q.source;
	assign new_entry.destination = req_q.destination;
	assign new_entry.timestamp   = req_q.timestamp;

	assign status.op        = req_q.operation;
	assign status.occ_zero  = (occ_q == '0);
	assign status.scan_last = (remain_q == OW'(1));
	assign status.out_free  = !out_valid_q || rsp_ready;

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	// entry store, one access per cycle
	always_ff @(posedge clk) begin
		if (do_write) mem[tail_q] <= new_entry;
		if (cmd.issue) rd_data_s1 <= mem[scan_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			scan_ptr_q  <= '0;
			remain_q    <= '0;
			rd_valid_s1 <= 1'b0;
			dup_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) limit_q <= cfg_data;

			rd_valid_s1 <= cmd.issue;

			if (cmd.start) begin
				scan_ptr_q <= head_q;
				remain_q   <= (req_q.operation == OP_FORWARD) ? OW'(1) : occ_q;
			end else if (cmd.issue) begin
				scan_ptr_q <= ptr_next(scan_ptr_q);
				remain_q   <= remain_q - OW'(1);
			end

			if (cmd.start) begin
				dup_q <= 1'b0;
				cnt_q <= '0;
			end else if (rd_valid_s1) begin
				if (hit_dup) dup_q <= 1'b1;
				if (hit_cnt && cnt_q != CNT_MAX) cnt_q <= cnt_q + 7'd1;
			end

			if (do_write) begin
				tail_q <= ptr_next(tail_q);
				// at the limit the oldest goes out silently, occupancy holds
				if (occ_q >= eff_limit) head_q <= ptr_next(head_q);
				else                    occ_q  <= occ_q + OW'(1);
			end else if (do_pop) begin
				head_q <= ptr_next(head_q);
				occ_q  <= occ_q - OW'(1);
			end

			if (cmd.commit)     out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		out_d = '0;
		case (req_q.operation)
			OP_ADD: begin
				out_d.accepted = !dup_q;
			end
			OP_FORWARD: begin
				if (occ_q != '0) begin
					out_d.packet_valid    = 1'b1;
					out_d.out_source      = rd_data_s1.source;
					out_d.out_destination = rd_data_s1.destination;
					out_d.out_timestamp   = rd_data_s1.timestamp;
				end
			end
			OP_COUNT: begin
				out_d.match_count = cnt_q;
			end
			default: begin
				out_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) out_q <= out_d;
	end

endmodule

FILE: sv/packet_buffer_dedup_range_count.sv
// Bounded FIFO packet buffer with duplicate rejection and a windowed count.
// One transaction on request carries an operation: add (rejected when
// source, destination and timestamp all match a stored packet, otherwise
// stored, dropping the oldest silently once occupancy reaches memory_limit),
// forward (pop oldest, packet_valid=0 when empty) or count (stored packets
// for a destination with start_time <= timestamp <= end_time, saturating at
// 127). Each request gives exactly one transaction on result; unused fields
// read 0, and operation code 3 changes nothing. Items are handled one at a
// time: add and count scan every stored entry, one slot per cycle through
// the entry RAM's single registered read port; forward reads only the
// oldest, and an empty buffer or code 3 skips the scan. A result waiting
// in the output register does not hold off the next request; only its own
// result waits. The user must write memory_limit (reset 64) on cfg only
// while idle; the block does not enforce it. 0 acts as 1, values above
// DEPTH act as DEPTH. Lowering it below occupancy drops nothing at once.
// Entries need no clearing after reset, so the block is ready right away.
module packet_buffer_dedup_range_count #(
	parameter int DEPTH = 64
) (
	input logic         clk,
	input logic         arst_n,
	pbdrc_stream_if.sink   request,
	pbdrc_stream_if.source result,
	pbdrc_stream_if.sink   cfg
);
	import pbdrc_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;
	logic         req_ready;
	logic         rsp_valid;
	rsp_item_t    rsp_data;

	// config must arrive only while idle, the block does not enforce it; always take it
	assign cfg.ready = 1'b1;

	assign request.ready = req_ready;
	assign result.valid  = rsp_valid;
	assign result.data   = rsp_data;

	// sequencer: capture, scan, commit
	pbdrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// entry RAM, pointers, compare/count and result register
	pbdrc_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg.valid),
		.cfg_data  (cfg.data),
		.req_data  (request.data),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_ready (result.ready),
		.rsp_data  (rsp_data)
	);

endmodule
